>>> rtl/dbfpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfpp_pkg
// Shared constants, codes and helpers of the decimating box filter.
// ----------------------------------------------------------------------------
package dbfpp_pkg;

    // row store depth, one entry per source column
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 16;
    localparam int WID_W     = 13;
    localparam int STEP_W    = 7;
    localparam int CFG_W     = 16;
    localparam int PIX_W     = 32;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_STEP       = 3'd2,
        REG_FORMAT     = 3'd3,
        REG_SWAP       = 3'd4
    } cfg_index_t;

    // output formats
    localparam logic [1:0] FMT_ARGB  = 2'd0;
    localparam logic [1:0] FMT_ALPHA = 2'd1;
    localparam logic [1:0] FMT_565   = 2'd2;
    localparam logic [1:0] FMT_NONE  = 2'd3;

    // ceil(2^16 / n): exact truncating divide for sums up to 9 * 255
    function automatic logic [16:0] recip(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dbfpp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfpp_if
// Valid/ready channels for source pixels and packed samples.
// ----------------------------------------------------------------------------
interface dbfpp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface dbfpp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic [11:0] out_x;
    logic [15:0] out_y;
    logic        image_last;

    modport source (output valid, output out_pixel, output out_x, output out_y,
                    output image_last, input ready);
    modport sink   (input valid, input out_pixel, input out_x, input out_y,
                    input image_last, output ready);
endinterface

>>> rtl/dbfpp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfpp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dbfpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/dbfpp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfpp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbfpp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [6:0]  divisor,
    output logic [15:0] quotient,
    output logic [6:0]  remainder,
    output logic        busy
);

    logic [15:0] quo_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [7:0]  trial;
    logic        fits;

    // one trial subtract per cycle
    assign trial = {rem_reg, quo_reg[15]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 5'd1;
            busy_reg <= (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[14:0], fits};
            rem_reg <= fits ? 7'(trial - {1'b0, div_reg}) : trial[6:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;

endmodule

>>> rtl/decimating_box_filter_pixel_pack.sv
`timescale 1ns / 1ps
// A pixel is accepted only in idle. It then goes through the row-store read,
// the step dividers, a check of four candidate sample points and a wait for
// each result word to be taken, so no new pixel is taken before the last is
// through. At ARGB with step one the word passes through unfiltered, and format
// three yields nothing; neither checks sample points.
// Reset clears counters, window and configuration; row stores are not cleared.
// ----------------------------------------------------------------------------
// decimating_box_filter_pixel_pack
// 3x3 box filter at decimated sample points, packed as ARGB8888, A8 or RGB565.
// ----------------------------------------------------------------------------
module decimating_box_filter_pixel_pack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  dbfpp_pkg::cfg_index_t cfg_index,
    input  logic [15:0]           cfg_data,
    dbfpp_in_if.sink              pixels,
    dbfpp_out_if.source           samples
);

    import dbfpp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_NEXT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [WID_W-1:0]  src_width_reg;
    logic [ROW_W-1:0]  src_height_reg;
    logic [STEP_W-1:0] step_reg;
    logic [1:0]        format_reg;
    logic              swap_reg;

    // position and window
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  win_reg [3][3];
    logic [1:0]        cand_reg;
    logic              pass_reg;

    // sum stage
    logic [11:0]       sum_reg [4];
    logic [3:0]        cnt_reg;
    logic              go_reg;
    logic [11:0]       sx_reg;
    logic [15:0]       sy_reg;
    logic              last_reg;

    // output word
    logic              out_valid_reg;
    logic [31:0]       out_pixel_reg;
    logic [11:0]       out_x_reg;
    logic [15:0]       out_y_reg;
    logic              out_last_reg;

    logic [WID_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [STEP_W-1:0] eff_s;
    logic              last_col, last_row;
    logic              accept, take;
    logic [PIX_W-1:0]  pix_in;
    logic [PIX_W-1:0]  up_rdata, mid_rdata;
    logic              ram_we;

    logic              div_start;
    logic [15:0]       qx, qy, qw, qh;
    logic [6:0]        rx, ry, rw, rh;
    logic              bx, by, bw, bh;

    // effective sizes
    always_comb
    begin
        if (src_width_reg == '0)
            eff_w = WID_W'(1);
        else if (src_width_reg > WID_W'(MAX_WIDTH))
            eff_w = WID_W'(MAX_WIDTH);
        else
            eff_w = src_width_reg;
    end
    assign eff_h = (src_height_reg == '0) ? ROW_W'(1) : src_height_reg;
    assign eff_s = (step_reg == '0) ? STEP_W'(1) : step_reg;

    assign last_col = ({1'b0, col_reg} + 13'd1) >= eff_w;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, eff_h};

    assign accept = pixels.valid && pixels.ready;
    assign take   = samples.valid && samples.ready;
    assign pixels.ready = (state_reg == S_IDLE);

    // optional red/blue swap on entry
    assign pix_in = swap_reg ? {pixels.pixel_word[31:24], pixels.pixel_word[7:0],
                                pixels.pixel_word[15:8], pixels.pixel_word[23:16]}
                             : pixels.pixel_word;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= WID_W'(1);
            src_height_reg <= ROW_W'(1);
            step_reg       <= STEP_W'(1);
            format_reg     <= FMT_ARGB;
            swap_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[WID_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[ROW_W-1:0];
                REG_STEP:       step_reg       <= cfg_data[STEP_W-1:0];
                REG_FORMAT:     format_reg     <= cfg_data[1:0];
                REG_SWAP:       swap_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // row stores: read at the column on accept, written back in the cycle after
    assign ram_we = (state_reg == S_READ);

    dbfpp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (mid_rdata),
        .raddr (col_reg),
        .rdata (up_rdata)
    );

    dbfpp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (col_reg),
        .rdata (mid_rdata)
    );

    // quotients and remainders of position and size by the step
    assign div_start = (state_reg == S_READ);

    dbfpp_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend({4'd0, col_reg}), .divisor(eff_s),
        .quotient(qx), .remainder(rx), .busy(bx));
    dbfpp_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(row_reg), .divisor(eff_s),
        .quotient(qy), .remainder(ry), .busy(by));
    dbfpp_div u_div_w (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend({3'd0, eff_w}), .divisor(eff_s),
        .quotient(qw), .remainder(rw), .busy(bw));
    dbfpp_div u_div_h (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(eff_h), .divisor(eff_s),
        .quotient(qh), .remainder(rh), .busy(bh));

    // sample point of the current candidate: column x-1 or x, row y-1 or y
    logic [15:0] qsx, qsy;
    logic [6:0]  rsx, rsy;
    logic        negx, negy, gx, gy, cand_en;
    logic        row_ok [3];
    logic        col_ok [3];
    logic [11:0] sum_c [4];
    logic [3:0]  cnt_c;

    always_comb
    begin
        if (cand_reg[0])
        begin
            qsx  = qx;
            rsx  = rx;
            negx = 1'b0;
        end
        else
        begin
            qsx  = (rx == '0) ? qx - 16'd1 : qx;
            rsx  = (rx == '0) ? eff_s - 7'd1 : rx - 7'd1;
            negx = (col_reg == '0);
        end
        if (cand_reg[1])
        begin
            qsy  = qy;
            rsy  = ry;
            negy = 1'b0;
        end
        else
        begin
            qsy  = (ry == '0) ? qy - 16'd1 : qy;
            rsy  = (ry == '0) ? eff_s - 7'd1 : ry - 7'd1;
            negy = (row_reg == '0);
        end
        gx = !negx && (rsx == '0) && (qsx < qw);
        gy = !negy && (rsy == '0) && (qsy < qh);
        case (cand_reg)
            2'd0:    cand_en = 1'b1;
            2'd1:    cand_en = last_col;
            2'd2:    cand_en = last_row;
            default: cand_en = last_col && last_row;
        endcase
    end

    // taps inside the image: window row r is source row y+r-2, column c is x+c-2
    always_comb
    begin
        logic [17:0] yr;
        logic [13:0] xc;
        logic        m;
        for (int r = 0; r < 3; r++)
        begin
            yr = {2'b0, row_reg} + 18'(r);
            row_ok[r] = (yr >= 18'd2) && ((yr - 18'd2) < {2'b0, eff_h});
        end
        for (int c = 0; c < 3; c++)
        begin
            xc = {2'b0, col_reg} + 14'(c);
            col_ok[c] = (xc >= 14'd2) && ((xc - 14'd2) < {1'b0, eff_w});
        end
        cnt_c = '0;
        for (int b = 0; b < 4; b++)
        begin
            sum_c[b] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m = row_ok[r] && col_ok[c] && (r >= int'(cand_reg[1]))
                    && (c >= int'(cand_reg[0]));
                if (m)
                begin
                    cnt_c = cnt_c + 4'd1;
                    for (int b = 0; b < 4; b++)
                    begin
                        sum_c[b] = sum_c[b] + {4'd0, win_reg[r][c][8*b +: 8]};
                    end
                end
            end
        end
    end

    // divide by the tap count, then pack
    logic [16:0] rcp;
    logic [28:0] prod [4];
    logic [7:0]  ch [4];
    logic [31:0] packed_pix;

    assign rcp = recip(cnt_reg);

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            prod[b] = {5'd0, sum_reg[b]} * {12'd0, rcp};
            ch[b]   = prod[b][23:16];
        end
        case (format_reg)
            FMT_ARGB:  packed_pix = {ch[3], ch[2], ch[1], ch[0]};
            FMT_ALPHA: packed_pix = {24'd0, ch[3]};
            default:   packed_pix = {16'd0, ch[0][7:3], ch[1][7:2], ch[2][7:3]};
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_READ;
            S_READ: state_next = S_DIV;
            S_DIV:
            begin
                if (!bx && !by && !bw && !bh)
                begin
                    if (format_reg == FMT_NONE)
                        state_next = S_NEXT;
                    else if (format_reg == FMT_ARGB && eff_s == STEP_W'(1))
                        state_next = ({1'b0, col_reg} < eff_w && row_reg < eff_h)
                                     ? S_WAIT : S_NEXT;
                    else
                        state_next = S_SUM;
                end
            end
            S_SUM: state_next = S_MUL;
            S_MUL:
            begin
                if (go_reg)
                    state_next = S_WAIT;
                else
                    state_next = (cand_reg == 2'd3) ? S_NEXT : S_SUM;
            end
            S_WAIT:
            begin
                if (take)
                    state_next = (pass_reg || cand_reg == 2'd3) ? S_NEXT : S_SUM;
            end
            S_NEXT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cand_reg      <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            // shift the window by one column
            if (state_reg == S_READ)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= up_rdata;
                win_reg[1][2] <= mid_rdata;
                win_reg[2][2] <= pix_reg;
            end
            if (state_reg == S_DIV)
            begin
                cand_reg <= '0;
                pass_reg <= (format_reg == FMT_ARGB && eff_s == STEP_W'(1));
                if (state_next == S_WAIT)
                    out_valid_reg <= 1'b1;
            end
            if (state_reg == S_MUL)
            begin
                if (go_reg)
                    out_valid_reg <= 1'b1;
                else if (cand_reg != 2'd3)
                    cand_reg <= cand_reg + 2'd1;
            end
            if (state_reg == S_WAIT && take)
            begin
                out_valid_reg <= 1'b0;
                if (!pass_reg && cand_reg != 2'd3)
                    cand_reg <= cand_reg + 2'd1;
            end
            // advance the raster position
            if (state_reg == S_NEXT)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + 12'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix_in;
        if (state_reg == S_SUM)
        begin
            for (int b = 0; b < 4; b++)
            begin
                sum_reg[b] <= sum_c[b];
            end
            cnt_reg  <= cnt_c;
            go_reg   <= cand_en && gx && gy;
            sx_reg   <= qsx[11:0];
            sy_reg   <= qsy;
            last_reg <= (qsx == qw - 16'd1) && (qsy == qh - 16'd1);
        end
        if (state_reg == S_MUL && go_reg)
        begin
            out_pixel_reg <= packed_pix;
            out_x_reg     <= sx_reg;
            out_y_reg     <= sy_reg;
            out_last_reg  <= last_reg;
        end
        if (state_reg == S_DIV)
        begin
            out_pixel_reg <= pix_reg;
            out_x_reg     <= col_reg;
            out_y_reg     <= row_reg;
            out_last_reg  <= last_col && last_row;
        end
    end

    assign samples.valid      = out_valid_reg;
    assign samples.out_pixel  = out_pixel_reg;
    assign samples.out_x      = out_x_reg;
    assign samples.out_y      = out_y_reg;
    assign samples.image_last = out_last_reg;

`ifndef SYNTHESIS
    // a result word is only presented while waiting for it to be taken
    a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_WAIT)
        else $error("result valid outside wait state");

    // an accepted pixel always reaches the row-store write back next
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("accepted pixel did not go to read");

    // dividers have finished before any sample is evaluated
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> !bx && !by && !bw && !bh)
        else $error("sample evaluated with divider busy");

    // raster position only moves at the end of an item
    a_pos_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_NEXT |=> $stable(col_reg) && $stable(row_reg))
        else $error("position changed mid item");
`endif

endmodule

>>> test/decimating_box_filter_pixel_pack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimating_box_filter_pixel_pack_tb
// Drives source pixel words through the box filter under several register
// settings. An in-bench predictor of the filter window, the row stores and the
// packing computes every sample, and each output word is checked field by field.
// ----------------------------------------------------------------------------
module decimating_box_filter_pixel_pack_tb;
    import dbfpp_pkg::*;

    typedef struct packed {
        logic [31:0] pix;
        logic [11:0] x;
        logic [15:0] y;
        logic        last;
    } sample_t;

    typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_index_t  idx;
        logic [31:0] value;
        bit          known;
        logic [31:0] want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [15:0] cfg_data;

    dbfpp_in_if  pixels ();
    dbfpp_out_if samples ();

    decimating_box_filter_pixel_pack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels.sink),
        .samples   (samples.source)
    );

    // predictor state
    bit [12:0] m_width;
    bit [15:0] m_height;
    bit [6:0]  m_step;
    bit [1:0]  m_fmt;
    bit        m_swap;
    bit [31:0] upper_row [MAX_WIDTH];
    bit [31:0] middle_row [MAX_WIDTH];
    int        col_pos;
    int        row_pos;
    bit [31:0] window [3][3];

    sample_t   pending_samples[$];
    sample_t   new_samples[$];
    int        errors;
    int        idle_mode;
    int        pixels_sent;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("FAIL decimating_box_filter_pixel_pack");
        $finish;
    end

    function automatic bit on_grid(int pos, int size, int s);
        return (pos % s) == 0 && pos < (size / s) * s;
    endfunction

    function automatic bit [31:0] pack_channels(int ch[4]);
        if (m_fmt == FMT_ARGB)
            return {ch[3][7:0], ch[2][7:0], ch[1][7:0], ch[0][7:0]};
        if (m_fmt == FMT_ALPHA)
            return ch[3];
        return ((ch[0] >> 3) << 11) | ((ch[1] >> 2) << 5) | (ch[2] >> 3);
    endfunction

    // average the in-image neighbors of the window cell (cr, cc)
    function automatic void box_sample(int cr, int cc, int x, int y, int w, int h, int s);
        int sy, sx, ry, rx, cnt;
        int sum[4];
        int ch[4];
        sample_t r;
        sy = y + cr - 2;
        sx = x + cc - 2;
        if (sy < 0 || sx < 0)
            return;
        if (!on_grid(sy, h, s) || !on_grid(sx, w, s))
            return;
        sum = '{0, 0, 0, 0};
        cnt = 0;
        for (int wr = cr - 1; wr <= cr + 1; wr++)
        begin
            for (int wc = cc - 1; wc <= cc + 1; wc++)
            begin
                if (wr < 0 || wr > 2 || wc < 0 || wc > 2)
                    continue;
                ry = y + wr - 2;
                rx = x + wc - 2;
                if (ry < 0 || rx < 0 || ry >= h || rx >= w)
                    continue;
                for (int b = 0; b < 4; b++)
                    sum[b] += (window[wr][wc] >> (8 * b)) & 8'hFF;
                cnt++;
            end
        end
        if (cnt == 0)
            cnt = 1;
        for (int b = 0; b < 4; b++)
            ch[b] = sum[b] / cnt;
        r.pix  = pack_channels(ch);
        r.x    = 12'(sx / s);
        r.y    = 16'(sy / s);
        r.last = (sx / s == w / s - 1) && (sy / s == h / s - 1);
        new_samples.push_back(r);
    endfunction

    // advance the filter by one source word, results go to new_samples
    function automatic void filter_pixel(bit [31:0] word);
        int w, h, s, x, y;
        bit [31:0] up, mid;
        bit last_col, last_row;
        sample_t r;
        w = (m_width == 0) ? 1 : m_width;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = (m_height == 0) ? 1 : m_height;
        s = (m_step == 0) ? 1 : m_step;
        x = col_pos;
        y = row_pos;
        last_col = x + 1 >= w;
        last_row = y + 1 >= h;
        if (m_swap)
            word = {word[31:24], word[7:0], word[15:8], word[23:16]};
        up = 0;
        mid = 0;
        if (x < MAX_WIDTH)
        begin
            up = upper_row[x];
            mid = middle_row[x];
            upper_row[x] = mid;
            middle_row[x] = word;
        end
        for (int i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = up;
        window[1][2] = mid;
        window[2][2] = word;

        if (m_fmt == FMT_NONE)
        begin
        end
        else if (m_fmt == FMT_ARGB && s == 1)
        begin
            if (x < w && y < h)
            begin
                r.pix = word;
                r.x = 12'(x);
                r.y = 16'(y);
                r.last = last_col && last_row;
                new_samples.push_back(r);
            end
        end
        else
        begin
            box_sample(1, 1, x, y, w, h, s);
            if (last_col)
                box_sample(1, 2, x, y, w, h, s);
            if (last_row)
            begin
                box_sample(2, 1, x, y, w, h, s);
                if (last_col)
                    box_sample(2, 2, x, y, w, h, s);
            end
        end

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((y + 1) & 16'hFFFF);
        end
        else
            col_pos = (x + 1) & 12'hFFF;
    endfunction

    // wait until the block is idle, including pixels that produce nothing
    task automatic drain();
        wait (pending_samples.size() == 0);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SRC_WIDTH:  m_width = v[12:0];
            REG_SRC_HEIGHT: m_height = v;
            REG_STEP:       m_step = v[6:0];
            REG_FORMAT:     m_fmt = v[1:0];
            REG_SWAP:       m_swap = v[0];
            default: ;
        endcase
    endtask

    task automatic set_all(int w, int h, int s, int f, int sw);
        drain();
        write_reg(REG_SRC_WIDTH, 16'(w));
        write_reg(REG_SRC_HEIGHT, 16'(h));
        write_reg(REG_STEP, 16'(s));
        write_reg(REG_FORMAT, 16'(f));
        write_reg(REG_SWAP, 16'(sw));
    endtask

    // send one word; a known row replaces the predicted expectation
    task automatic send_word(logic [31:0] word, bit known, logic [31:0] want);
        sample_t r;
        @(negedge clk);
        while ((idle_mode == 1 && $urandom_range(99) < 53) ||
               (idle_mode == 3 && $urandom_range(99) < 37))
        begin
            pixels.valid = 1'b0;
            @(negedge clk);
        end
        pixels.valid = 1'b1;
        pixels.pixel_word = word;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        new_samples.delete();
        filter_pixel(word);
        if (known)
        begin
            r.pix = want;
            r.x = 0;
            r.y = 0;
            r.last = 1'b1;
            pending_samples.push_back(r);
        end
        else
        begin
            foreach (new_samples[i])
                pending_samples.push_back(new_samples[i]);
        end
        pixels_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        pixels.valid = 1'b0;
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
            samples.ready <= !((idle_mode == 2 && $urandom_range(99) < 53) ||
                               (idle_mode == 3 && $urandom_range(99) < 37));
    end

    // compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        sample_t got, want;
        if (rst_n && samples.valid && samples.ready)
        begin
            got = {samples.out_pixel, samples.out_x, samples.out_y, samples.image_last};
            if (pending_samples.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (got.pix !== want.pix)
                begin
                    $display("%0t out_pixel: expected %h, actual %h", $realtime,
                             want.pix, got.pix);
                    errors++;
                end
                if (got.x !== want.x)
                begin
                    $display("%0t out_x: expected %0d, actual %0d", $realtime, want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $display("%0t out_y: expected %0d, actual %0d", $realtime, want.y, got.y);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t image_last: expected %b, actual %b", $realtime,
                             want.last, got.last);
                    errors++;
                end
            end
        end
    end

    stim_row_t directed[$];

    function automatic void add_cfg(cfg_index_t idx, int v);
        directed.push_back('{ROW_CFG, idx, 32'(v), 1'b0, 32'h0});
    endfunction

    function automatic void add_pix(logic [31:0] v, bit known);
        directed.push_back('{ROW_PIX, REG_SRC_WIDTH, v, known, v});
    endfunction

    initial
    begin
        int w, h, s, n, rand_items, phase;
        errors = 0;
        idle_mode = 0;
        pixels_sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_data = '0;
        pixels.valid = 1'b0;
        pixels.pixel_word = '0;
        samples.ready = 1'b1;
        m_width = 13'd1;
        m_height = 16'd1;
        m_step = 7'd1;
        m_fmt = FMT_ARGB;
        m_swap = 1'b0;
        col_pos = 0;
        row_pos = 0;
        foreach (upper_row[i])
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        foreach (window[i, j])
            window[i][j] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: 1x1 ARGB pass-through, every word is its own image
        add_pix(32'h0000_0000, 1);
        add_pix(32'hFFFF_FFFF, 1);
        add_pix(32'hAAAA_5555, 1);
        add_pix(32'h8000_0001, 1);
        // 3x3 alpha with red/blue swap, edge neighborhoods shrink
        add_cfg(REG_SRC_WIDTH, 3);
        add_cfg(REG_SRC_HEIGHT, 3);
        add_cfg(REG_FORMAT, FMT_ALPHA);
        add_cfg(REG_SWAP, 1);
        add_pix(32'hFF00_00FF, 0);
        add_pix(32'h0000_0000, 0);
        add_pix(32'hFFFF_FFFF, 0);
        add_pix(32'h7F80_0102, 0);
        add_pix(32'h0102_0304, 0);
        add_pix(32'hFEFD_FCFB, 0);
        add_pix(32'h1234_5678, 0);
        add_pix(32'h00FF_00FF, 0);
        add_pix(32'hFF00_FF00, 0);
        // zero width and zero step count as one, RGB565
        add_cfg(REG_SRC_WIDTH, 0);
        add_cfg(REG_STEP, 0);
        add_cfg(REG_FORMAT, FMT_565);
        add_pix(32'hFFFF_FFFF, 0);
        add_pix(32'h00F8_FCF8, 0);
        add_pix(32'h0007_0307, 0);
        // format three consumes words and yields nothing
        add_cfg(REG_FORMAT, FMT_NONE);
        add_cfg(REG_SRC_HEIGHT, 0);
        add_pix(32'hDEAD_BEEF, 0);
        add_pix(32'h1111_1111, 0);
        add_pix(32'h2222_2222, 0);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                stop_sending();
                drain();
                write_reg(directed[i].idx, directed[i].value[15:0]);
            end
            else
                send_word(directed[i].value, directed[i].known, directed[i].value);
        end
        stop_sending();

        // widest setting: width clamps to the row store, start of the first row
        set_all(8191, 2, 1, FMT_565, 0);
        for (int i = 0; i < 16; i++)
            send_word($urandom, 1'b0, 32'h0);
        stop_sending();

        // step of 64: one sample, image left unfinished
        set_all(64, 64, 64, FMT_ARGB, 1);
        for (int i = 0; i < 66; i++)
            send_word($urandom, 1'b0, 32'h0);
        stop_sending();

        // random images, idling pattern rotates each phase
        rand_items = 0;
        phase = 0;
        while (rand_items < 110)
        begin
            w = $urandom_range(1, 9);
            h = ($urandom_range(9) == 0) ? 65535 : $urandom_range(1, 8);
            case ($urandom_range(5))
                0:       s = 0;
                1:       s = 2;
                2:       s = 3;
                default: s = 1;
            endcase
            set_all(w, h, s, $urandom_range(3), $urandom_range(1));
            idle_mode = phase % 4;
            n = (h == 65535) ? $urandom_range(1, 3 * w) :
                ($urandom_range(5) == 0) ? $urandom_range(1, w * h) : w * h;
            for (int i = 0; i < n; i++)
                send_word($urandom, 1'b0, 32'h0);
            stop_sending();
            rand_items += n;
            phase++;
        end

        drain();
        if (errors == 0)
            $display("PASS decimating_box_filter_pixel_pack");
        else
            $display("FAIL decimating_box_filter_pixel_pack");
        $finish;
    end

endmodule

>>> files.f
rtl/dbfpp_pkg.sv
rtl/dbfpp_if.sv
rtl/dbfpp_ram.sv
rtl/dbfpp_div.sv
rtl/decimating_box_filter_pixel_pack.sv
test/decimating_box_filter_pixel_pack_tb.sv
